// ===== rtl/assert_macros.svh =====
// Assertion helpers, sampled on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/plfw_pkg.sv =====
`timescale 1ns / 1ps

package plfw_pkg;

  localparam int PAL_ENTRIES = 4096;
  localparam int NUM_BANKS   = 3;
  localparam int BANK_AW     = $clog2(PAL_ENTRIES);
  localparam int TABLE_DEPTH = NUM_BANKS * PAL_ENTRIES;

  localparam logic [15:0] IDX_MASK = 16'(TABLE_DEPTH - 1);
  localparam logic [15:0] BASE_1   = 16'(PAL_ENTRIES);
  localparam logic [15:0] BASE_2   = 16'(2 * PAL_ENTRIES);
  localparam logic [15:0] BASE_3   = 16'(3 * PAL_ENTRIES);

  localparam logic [1:0] OP_PALETTE = 2'd0;
  localparam logic [1:0] OP_PIXEL   = 2'd1;
  localparam logic [1:0] OP_FRAME   = 2'd2;

  localparam logic [1:0] BANK_0    = 2'd0;
  localparam logic [1:0] BANK_1    = 2'd1;
  localparam logic [1:0] BANK_2    = 2'd2;
  localparam logic [1:0] BANK_NONE = 2'd3;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;
  localparam logic [CFG_IW-1:0] CFG_BYTE_SWAP  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_WIDTH      = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_STRIDE     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_TOP_LEFT   = 3'd4;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic        byte_swap;
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [12:0] row_stride;
    logic [23:0] top_left;
  } cfg_t;

  typedef struct packed {
    logic cmdq_full;
    logic clearing;
  } front_stat_t;

  typedef struct packed {
    logic               is_write;
    logic [1:0]         bank;
    logic [BANK_AW-1:0] offset;
    logic [15:0]        normal;
    logic [15:0]        shadow;
    logic [23:0]        prod;
    logic [10:0]        col;
  } cmd_t;

  typedef struct packed {
    logic [23:0] addr;
    logic [15:0] colour;
  } out_t;

endpackage

// ===== rtl/palette_lookup_framebuffer_writer.sv =====
// A drawn pixel goes through the command queue, RAM read stage and result queue to the
// ports. One item per cycle while full is low and the result queue has room; a palette
// write fills its bank and every higher bank. Undrawn pixels, frame starts and unused
// opcodes give no result. Reset: synchronous, active low; then a clear pass (one entry
// of each bank per cycle) holds full high. Configuration writes are taken meanwhile.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module palette_lookup_framebuffer_writer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_opcode,
  input  logic [12:0]                   in_palette_byte_addr,
  input  logic [4:0]                    in_red,
  input  logic [4:0]                    in_green,
  input  logic [4:0]                    in_blue,
  input  logic [15:0]                   in_pixel_index,
  output logic                          empty,
  input  logic                          pop,
  output logic [23:0]                   out_write_addr,
  output logic [15:0]                   out_colour,
  input  logic                          cfg_we,
  input  logic [plfw_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [plfw_pkg::CFG_DW-1:0]   cfg_data
);

  logic        byte_swap_r;
  logic [10:0] frame_width_r;
  logic [10:0] frame_height_r;
  logic [12:0] row_stride_r;
  logic [23:0] top_left_r;

  plfw_pkg::cfg_t        cfg;
  plfw_pkg::front_stat_t stat;
  plfw_pkg::cmd_t        cmd_in;
  plfw_pkg::cmd_t        cmd_out;
  logic                  cmd_push;
  logic                  cmd_pop;
  logic                  cmd_full;
  logic                  cmd_empty;
  logic                  clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_swap_r    <= 1'b0;
      frame_width_r  <= 11'd320;
      frame_height_r <= 11'd224;
      row_stride_r   <= 13'd320;
      top_left_r     <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plfw_pkg::CFG_BYTE_SWAP: byte_swap_r    <= cfg_data[0];
        plfw_pkg::CFG_WIDTH:     frame_width_r  <= cfg_data[10:0];
        plfw_pkg::CFG_HEIGHT:    frame_height_r <= cfg_data[10:0];
        plfw_pkg::CFG_STRIDE:    row_stride_r   <= cfg_data[12:0];
        plfw_pkg::CFG_TOP_LEFT:  top_left_r     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{byte_swap: byte_swap_r, frame_width: frame_width_r,
                 frame_height: frame_height_r, row_stride: row_stride_r,
                 top_left: top_left_r};
  assign stat = '{cmdq_full: cmd_full, clearing: clearing};

  plfw_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_opcode           (in_opcode),
    .in_palette_byte_addr(in_palette_byte_addr),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .in_pixel_index      (in_pixel_index),
    .cfg                 (cfg),
    .stat                (stat),
    .cmd_push            (cmd_push),
    .cmd                 (cmd_in)
  );

  plfw_cmdq u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .din  (cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (cmd_out),
    .empty(cmd_empty)
  );

  plfw_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd_out),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .top_left      (top_left_r),
    .clearing      (clearing),
    .pop           (pop),
    .empty         (empty),
    .out_write_addr(out_write_addr),
    .out_colour    (out_colour)
  );

  `ASSERT_NOW(a_clear_blocks_input, clearing, full)
  `ASSERT_NOW(a_clear_no_results, clearing, empty)
  `ASSERT_NOW(a_pop_legal, cmd_pop, !cmd_empty && !clearing)
  `ASSERT_NEXT(a_clear_once, !clearing, !clearing)

endmodule

// ===== rtl/plfw_ram.sv =====
`timescale 1ns / 1ps

module plfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/plfw_front.sv =====
`timescale 1ns / 1ps

module plfw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           in_opcode,
  input  logic [12:0]          in_palette_byte_addr,
  input  logic [4:0]           in_red,
  input  logic [4:0]           in_green,
  input  logic [4:0]           in_blue,
  input  logic [15:0]          in_pixel_index,
  input  plfw_pkg::cfg_t       cfg,
  input  plfw_pkg::front_stat_t stat,
  output logic                 cmd_push,
  output plfw_pkg::cmd_t       cmd
);

  function automatic logic [15:0] pack565(input logic [4:0] r, input logic [5:0] g,
                                          input logic [4:0] b, input logic swap);
    logic [15:0] w;
    w = {r, g, b};
    return swap ? {w[7:0], w[15:8]} : w;
  endfunction

  function automatic logic [5:0] scale6(input logic [5:0] c);
    logic [13:0] p;
    p = {8'd0, c} * 14'd202;
    return p[13:8];
  endfunction

  function automatic logic [1:0] bank_of(input logic [15:0] v);
    logic [1:0] b;
    if (v < plfw_pkg::BASE_1) begin
      b = plfw_pkg::BANK_0;
    end else if (v < plfw_pkg::BASE_2) begin
      b = plfw_pkg::BANK_1;
    end else if (v < plfw_pkg::BASE_3) begin
      b = plfw_pkg::BANK_2;
    end else begin
      b = plfw_pkg::BANK_NONE;
    end
    return b;
  endfunction

  function automatic logic [15:0] base_of(input logic [1:0] b);
    logic [15:0] base;
    unique case (b)
      plfw_pkg::BANK_0: base = 16'd0;
      plfw_pkg::BANK_1: base = plfw_pkg::BASE_1;
      plfw_pkg::BANK_2: base = plfw_pkg::BASE_2;
      default:          base = plfw_pkg::BASE_3;
    endcase
    return base;
  endfunction

  logic [10:0] col_r, col_nxt;
  logic [10:0] row_r, row_nxt;

  logic        accept;
  logic        row_ok;
  logic        drawn;
  logic [10:0] col_inc;
  logic [15:0] entry;
  logic [15:0] idx;
  logic [1:0]  ent_bank;
  logic [1:0]  idx_bank;
  logic [15:0] ent_off;
  logic [15:0] idx_off;
  logic [5:0]  g6;

  assign full   = stat.cmdq_full || stat.clearing;
  assign accept = push && !full;

  always_comb begin
    row_ok   = row_r < cfg.frame_height;
    drawn    = col_r < (cfg.frame_width & 11'h7F0);
    col_inc  = col_r + 11'd1;
    col_nxt  = col_r;
    row_nxt  = row_r;
    cmd_push = 1'b0;
    if (accept) begin
      unique case (in_opcode)
        plfw_pkg::OP_PALETTE: cmd_push = 1'b1;
        plfw_pkg::OP_PIXEL: begin
          if (row_ok) begin
            cmd_push = drawn;
            if (col_inc >= cfg.frame_width) begin
              col_nxt = 11'd0;
              row_nxt = row_r + 11'd1;
            end else begin
              col_nxt = col_inc;
            end
          end
        end
        plfw_pkg::OP_FRAME: begin
          col_nxt = 11'd0;
          row_nxt = 11'd0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    entry    = {4'd0, in_palette_byte_addr[12:1]};
    idx      = in_pixel_index & plfw_pkg::IDX_MASK;
    ent_bank = bank_of(entry);
    idx_bank = bank_of(idx);
    ent_off  = entry - base_of(ent_bank);
    idx_off  = idx - base_of(idx_bank);
    g6       = {in_green, 1'b0};

    cmd.is_write = (in_opcode == plfw_pkg::OP_PALETTE);
    cmd.bank     = cmd.is_write ? ent_bank : idx_bank;
    cmd.offset   = cmd.is_write ? ent_off[plfw_pkg::BANK_AW-1:0]
                                : idx_off[plfw_pkg::BANK_AW-1:0];
    cmd.normal   = pack565(in_red, g6, in_blue, cfg.byte_swap);
    cmd.shadow   = pack565(scale6({1'b0, in_red}) >> 0 == 6'd0 ? 5'd0
                           : 5'(scale6({1'b0, in_red})),
                           scale6(g6), 5'(scale6({1'b0, in_blue})), cfg.byte_swap);
    cmd.prod     = {13'd0, row_r} * {11'd0, cfg.row_stride};
    cmd.col      = col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 11'd0;
      row_r <= 11'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== rtl/plfw_cmdq.sv =====
`timescale 1ns / 1ps

module plfw_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  plfw_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output plfw_pkg::cmd_t dout,
  output logic           empty
);

  localparam logic [plfw_pkg::CMDQ_AW-1:0] LAST = plfw_pkg::CMDQ_AW'(plfw_pkg::CMDQ_DEPTH - 1);

  plfw_pkg::cmd_t mem_r [plfw_pkg::CMDQ_DEPTH];

  logic [plfw_pkg::CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [plfw_pkg::CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [plfw_pkg::CMDQ_CW-1:0] count_r, count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full  = count_r == plfw_pkg::CMDQ_CW'(plfw_pkg::CMDQ_DEPTH);
  assign empty = count_r == '0;
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/plfw_back.sv =====
`timescale 1ns / 1ps

module plfw_back (
  input  logic           clk,
  input  logic           rst_n,
  input  plfw_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  logic [23:0]    top_left,
  output logic           clearing,
  input  logic           pop,
  output logic           empty,
  output logic [23:0]    out_write_addr,
  output logic [15:0]    out_colour
);

  localparam int AW = plfw_pkg::BANK_AW;
  localparam logic [AW-1:0] CLR_LAST = AW'(plfw_pkg::PAL_ENTRIES - 1);
  localparam logic [plfw_pkg::OQ_AW-1:0] OQ_LAST = plfw_pkg::OQ_AW'(plfw_pkg::OQ_DEPTH - 1);

  logic          clr_r, clr_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic          ram_we    [plfw_pkg::NUM_BANKS];
  logic [15:0]   ram_wdata [plfw_pkg::NUM_BANKS];
  logic [15:0]   ram_rdata [plfw_pkg::NUM_BANKS];
  logic [AW-1:0] ram_waddr;

  logic          issue;
  logic          room;
  logic          v1_r, v1_nxt;
  logic [1:0]    sel1_r;
  logic [23:0]   addr1_r;
  logic [15:0]   colour1;

  plfw_pkg::out_t               oq_r [plfw_pkg::OQ_DEPTH];
  logic [plfw_pkg::OQ_AW-1:0]   oq_wr_r, oq_wr_nxt;
  logic [plfw_pkg::OQ_AW-1:0]   oq_rd_r, oq_rd_nxt;
  logic [plfw_pkg::OQ_CW-1:0]   oq_cnt_r, oq_cnt_nxt;
  logic [plfw_pkg::OQ_CW:0]     oq_pending;
  logic                         oq_pop;

  assign clearing = clr_r;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      if (clr_addr_r == CLR_LAST) begin
        clr_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_comb begin
    oq_pending = {1'b0, oq_cnt_r} + (plfw_pkg::OQ_CW + 1)'(v1_r);
    room       = oq_pending < (plfw_pkg::OQ_CW + 1)'(plfw_pkg::OQ_DEPTH);
    issue      = !cmd_empty && !clr_r && (cmd.is_write || room);
    cmd_pop    = issue;
    ram_waddr  = clr_r ? clr_addr_r : cmd.offset;
    for (int k = 0; k < plfw_pkg::NUM_BANKS; k++) begin
      ram_we[k]    = clr_r || (issue && cmd.is_write && (cmd.bank <= 2'(k)));
      ram_wdata[k] = clr_r ? 16'd0 : ((cmd.bank == 2'(k)) ? cmd.normal : cmd.shadow);
    end
    v1_nxt = issue && !cmd.is_write;
  end

  for (genvar k = 0; k < plfw_pkg::NUM_BANKS; k++) begin : g_bank
    plfw_ram #(
      .WIDTH(16),
      .DEPTH(plfw_pkg::PAL_ENTRIES)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we[k]),
      .waddr(ram_waddr),
      .wdata(ram_wdata[k]),
      .raddr(cmd.offset),
      .rdata(ram_rdata[k])
    );
  end

  always_comb begin
    unique case (sel1_r)
      plfw_pkg::BANK_0: colour1 = ram_rdata[0];
      plfw_pkg::BANK_1: colour1 = ram_rdata[1];
      default:          colour1 = ram_rdata[2];
    endcase
  end

  // result queue
  always_comb begin
    oq_pop     = pop && !empty;
    oq_wr_nxt  = oq_wr_r;
    oq_rd_nxt  = oq_rd_r;
    if (v1_r) begin
      oq_wr_nxt = (oq_wr_r == OQ_LAST) ? '0 : oq_wr_r + 1'b1;
    end
    if (oq_pop) begin
      oq_rd_nxt = (oq_rd_r == OQ_LAST) ? '0 : oq_rd_r + 1'b1;
    end
    unique case ({v1_r, oq_pop})
      2'b10:   oq_cnt_nxt = oq_cnt_r + 1'b1;
      2'b01:   oq_cnt_nxt = oq_cnt_r - 1'b1;
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  assign empty          = oq_cnt_r == '0;
  assign out_write_addr = oq_r[oq_rd_r].addr;
  assign out_colour     = oq_r[oq_rd_r].colour;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      v1_r       <= 1'b0;
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_cnt_r   <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
      v1_r       <= v1_nxt;
      oq_wr_r    <= oq_wr_nxt;
      oq_rd_r    <= oq_rd_nxt;
      oq_cnt_r   <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel1_r  <= cmd.bank;
    addr1_r <= top_left + cmd.prod + {13'd0, cmd.col};
    if (v1_r) begin
      oq_r[oq_wr_r] <= '{addr: addr1_r, colour: colour1};
    end
  end

endmodule
